@@ sv/vtsg_pkg.sv @@
// Shared types, constants and the stroke-font tables of the vector text segment generator.
// No dependencies; imported by the controller, the datapath and the top level.
package vtsg_pkg;

  localparam int ROM_USED   = 215;  // points in the stroke font
  localparam int ROM_AW     = 8;
  localparam int PT_HW      = 6;    // signed half-unit point coordinate
  localparam int SCALE_W    = 12;
  localparam int SW_W       = 15;
  localparam int CHAR_W     = 8;
  localparam int ORG_W      = 16;
  localparam int COLOR_W    = 32;
  localparam int SEG_W      = 16;
  localparam int CNT_W      = 4;
  localparam int HALF_SHIFT = 9;    // half units and Q4.8 fraction
  localparam int FRAC_SHIFT = 8;
  localparam int PEN_ADV    = 11;
  localparam int LINE_ADV   = 19;
  localparam int WRAP_MARGIN = 11;

  localparam logic [1:0] REG_SCALE_X  = 2'd0;
  localparam logic [1:0] REG_SCALE_Y  = 2'd1;
  localparam logic [1:0] REG_SCREEN_W = 2'd2;

  typedef struct packed {
    logic                    start;
    logic signed [PT_HW-1:0] hx;
    logic signed [PT_HW-1:0] hy;
  } pt_t;

  typedef struct packed {
    logic              known;
    logic [ROM_AW-1:0] base;
    logic [CNT_W-1:0]  cnt;
  } glyph_t;

  typedef struct packed {
    logic load;      // latch the accepted character
    logic step;      // advance the point pipe
    logic issue;     // fetch and scale the next font point
    logic pen_adv;   // add the glyph advance to the pen
    logic wrap_chk;  // test the pen against the screen width
  } dp_cmd_t;

  typedef struct packed {
    logic known;
    logic empty;
    logic fetch_more;
    logic pt_vld;
    logic pt_start;
    logic out_free;
  } dp_status_t;

  function automatic pt_t mk(input logic s, input int x, input int y);
    pt_t p;
    p.start = s;
    p.hx    = PT_HW'(x);
    p.hy    = PT_HW'(y);
    return p;
  endfunction

  // Font points in half units; a start point opens a new polyline.
  function automatic pt_t glyph_pt(input logic [ROM_AW-1:0] a);
    pt_t p;
    unique case (a)
      // 0
      8'd0:   p = mk(1, 0, 0);
      8'd1:   p = mk(0, 0, -32);
      8'd2:   p = mk(0, 16, -32);
      8'd3:   p = mk(0, 16, 0);
      8'd4:   p = mk(0, 0, 0);
      8'd5:   p = mk(0, 0, 0);
      8'd6:   p = mk(0, 16, -32);
      // 1
      8'd7:   p = mk(1, 4, 0);
      8'd8:   p = mk(0, 12, 0);
      8'd9:   p = mk(1, 8, 0);
      8'd10:  p = mk(0, 8, -32);
      8'd11:  p = mk(0, 6, -32);
      // 2
      8'd12:  p = mk(1, 0, -32);
      8'd13:  p = mk(0, 16, -32);
      8'd14:  p = mk(0, 16, -16);
      8'd15:  p = mk(0, 0, -16);
      8'd16:  p = mk(0, 0, 0);
      8'd17:  p = mk(0, 16, 0);
      // 3
      8'd18:  p = mk(1, 0, -32);
      8'd19:  p = mk(0, 16, -32);
      8'd20:  p = mk(0, 16, 0);
      8'd21:  p = mk(0, 0, 0);
      8'd22:  p = mk(1, 4, -16);
      8'd23:  p = mk(0, 16, -16);
      // 4
      8'd24:  p = mk(1, 0, -32);
      8'd25:  p = mk(0, 0, -16);
      8'd26:  p = mk(0, 16, -16);
      8'd27:  p = mk(1, 16, -32);
      8'd28:  p = mk(0, 16, 0);
      // 5
      8'd29:  p = mk(1, 16, -32);
      8'd30:  p = mk(0, 0, -32);
      8'd31:  p = mk(0, 0, -16);
      8'd32:  p = mk(0, 16, -16);
      8'd33:  p = mk(0, 16, 0);
      8'd34:  p = mk(0, 0, 0);
      // 6
      8'd35:  p = mk(1, 16, -32);
      8'd36:  p = mk(0, 0, -32);
      8'd37:  p = mk(0, 0, 0);
      8'd38:  p = mk(0, 16, 0);
      8'd39:  p = mk(0, 16, -16);
      8'd40:  p = mk(0, 0, -16);
      // 7
      8'd41:  p = mk(1, 0, -32);
      8'd42:  p = mk(0, 16, -32);
      8'd43:  p = mk(0, 16, 0);
      // 8
      8'd44:  p = mk(1, 0, 0);
      8'd45:  p = mk(0, 0, -32);
      8'd46:  p = mk(0, 16, -32);
      8'd47:  p = mk(0, 16, 0);
      8'd48:  p = mk(0, 0, 0);
      8'd49:  p = mk(1, 0, -16);
      8'd50:  p = mk(0, 16, -16);
      // 9
      8'd51:  p = mk(1, 0, 0);
      8'd52:  p = mk(0, 16, 0);
      8'd53:  p = mk(0, 16, -32);
      8'd54:  p = mk(0, 0, -32);
      8'd55:  p = mk(0, 0, -16);
      8'd56:  p = mk(0, 16, -16);
      // A
      8'd57:  p = mk(1, 0, 0);
      8'd58:  p = mk(0, 8, -32);
      8'd59:  p = mk(0, 16, 0);
      8'd60:  p = mk(1, 4, -16);
      8'd61:  p = mk(0, 12, -16);
      // B
      8'd62:  p = mk(1, 0, 0);
      8'd63:  p = mk(0, 0, -32);
      8'd64:  p = mk(0, 16, -24);
      8'd65:  p = mk(0, 0, -16);
      8'd66:  p = mk(0, 16, -8);
      8'd67:  p = mk(0, 0, 0);
      // C
      8'd68:  p = mk(1, 16, 0);
      8'd69:  p = mk(0, 0, 0);
      8'd70:  p = mk(0, 0, -32);
      8'd71:  p = mk(0, 16, -32);
      // D
      8'd72:  p = mk(1, 0, 0);
      8'd73:  p = mk(0, 0, -32);
      8'd74:  p = mk(0, 16, -16);
      8'd75:  p = mk(0, 0, 0);
      // E
      8'd76:  p = mk(1, 16, 0);
      8'd77:  p = mk(0, 0, 0);
      8'd78:  p = mk(0, 0, -32);
      8'd79:  p = mk(0, 16, -32);
      8'd80:  p = mk(1, 0, -16);
      8'd81:  p = mk(0, 12, -16);
      // F
      8'd82:  p = mk(1, 0, 0);
      8'd83:  p = mk(0, 0, -32);
      8'd84:  p = mk(0, 16, -32);
      8'd85:  p = mk(1, 0, -16);
      8'd86:  p = mk(0, 12, -16);
      // G
      8'd87:  p = mk(1, 16, -32);
      8'd88:  p = mk(0, 0, -32);
      8'd89:  p = mk(0, 0, 0);
      8'd90:  p = mk(0, 16, 0);
      8'd91:  p = mk(0, 16, -16);
      8'd92:  p = mk(0, 8, -16);
      8'd93:  p = mk(0, 8, -12);
      // H
      8'd94:  p = mk(1, 0, 0);
      8'd95:  p = mk(0, 0, -32);
      8'd96:  p = mk(1, 0, -16);
      8'd97:  p = mk(0, 16, -16);
      8'd98:  p = mk(1, 16, 0);
      8'd99:  p = mk(0, 16, -32);
      // I
      8'd100: p = mk(1, 6, 0);
      8'd101: p = mk(0, 10, 0);
      8'd102: p = mk(1, 6, -32);
      8'd103: p = mk(0, 10, -32);
      8'd104: p = mk(1, 8, 0);
      8'd105: p = mk(0, 8, -32);
      // J
      8'd106: p = mk(1, 16, -32);
      8'd107: p = mk(0, 16, 0);
      8'd108: p = mk(0, 0, 0);
      8'd109: p = mk(0, 0, -8);
      // K
      8'd110: p = mk(1, 0, 0);
      8'd111: p = mk(0, 0, -32);
      8'd112: p = mk(1, 16, -32);
      8'd113: p = mk(0, 0, -16);
      8'd114: p = mk(0, 16, 0);
      // L
      8'd115: p = mk(1, 0, -32);
      8'd116: p = mk(0, 0, 0);
      8'd117: p = mk(0, 16, 0);
      // M
      8'd118: p = mk(1, 0, 0);
      8'd119: p = mk(0, 0, -32);
      8'd120: p = mk(0, 8, -16);
      8'd121: p = mk(0, 16, -32);
      8'd122: p = mk(0, 16, 0);
      // N
      8'd123: p = mk(1, 0, 0);
      8'd124: p = mk(0, 0, -32);
      8'd125: p = mk(0, 16, 0);
      8'd126: p = mk(0, 16, -32);
      // O
      8'd127: p = mk(1, 0, 0);
      8'd128: p = mk(0, 0, -32);
      8'd129: p = mk(0, 16, -32);
      8'd130: p = mk(0, 16, 0);
      8'd131: p = mk(0, 0, 0);
      // P
      8'd132: p = mk(1, 0, 0);
      8'd133: p = mk(0, 0, -32);
      8'd134: p = mk(0, 16, -32);
      8'd135: p = mk(0, 16, -16);
      8'd136: p = mk(0, 0, -16);
      // Q
      8'd137: p = mk(1, 0, 0);
      8'd138: p = mk(0, 0, -32);
      8'd139: p = mk(0, 16, -32);
      8'd140: p = mk(0, 16, 0);
      8'd141: p = mk(0, 0, 0);
      8'd142: p = mk(1, 16, 0);
      8'd143: p = mk(0, 8, -8);
      // R
      8'd144: p = mk(1, 0, 0);
      8'd145: p = mk(0, 0, -32);
      8'd146: p = mk(0, 16, -32);
      8'd147: p = mk(0, 16, -16);
      8'd148: p = mk(0, 0, -16);
      8'd149: p = mk(1, 8, -16);
      8'd150: p = mk(0, 16, 0);
      // S
      8'd151: p = mk(1, 16, -32);
      8'd152: p = mk(0, 0, -32);
      8'd153: p = mk(0, 0, -16);
      8'd154: p = mk(0, 16, -16);
      8'd155: p = mk(0, 16, 0);
      8'd156: p = mk(0, 0, 0);
      // T
      8'd157: p = mk(1, 0, -32);
      8'd158: p = mk(0, 16, -32);
      8'd159: p = mk(1, 8, 0);
      8'd160: p = mk(0, 8, -32);
      // U
      8'd161: p = mk(1, 0, -32);
      8'd162: p = mk(0, 0, 0);
      8'd163: p = mk(0, 16, 0);
      8'd164: p = mk(0, 16, -32);
      // V
      8'd165: p = mk(1, 0, -32);
      8'd166: p = mk(0, 8, 0);
      8'd167: p = mk(0, 16, -32);
      // W
      8'd168: p = mk(1, 0, -32);
      8'd169: p = mk(0, 4, 0);
      8'd170: p = mk(0, 8, -16);
      8'd171: p = mk(0, 12, 0);
      8'd172: p = mk(0, 16, -32);
      // X
      8'd173: p = mk(1, 0, -32);
      8'd174: p = mk(0, 16, 0);
      8'd175: p = mk(1, 16, -32);
      8'd176: p = mk(0, 0, 0);
      // Y
      8'd177: p = mk(1, 0, -32);
      8'd178: p = mk(0, 8, -16);
      8'd179: p = mk(0, 16, -32);
      8'd180: p = mk(1, 8, -16);
      8'd181: p = mk(0, 8, 0);
      // Z
      8'd182: p = mk(1, 0, -32);
      8'd183: p = mk(0, 16, -32);
      8'd184: p = mk(0, 0, 0);
      8'd185: p = mk(0, 16, 0);
      // comma
      8'd186: p = mk(1, 8, -6);
      8'd187: p = mk(0, 10, -6);
      8'd188: p = mk(0, 10, -4);
      8'd189: p = mk(0, 8, -2);
      8'd190: p = mk(0, 9, -4);
      8'd191: p = mk(0, 8, -4);
      8'd192: p = mk(0, 8, -6);
      // colon
      8'd193: p = mk(1, 8, -6);
      8'd194: p = mk(0, 10, -6);
      8'd195: p = mk(0, 10, -4);
      8'd196: p = mk(0, 8, -4);
      8'd197: p = mk(0, 8, -6);
      8'd198: p = mk(1, 8, -28);
      8'd199: p = mk(0, 10, -28);
      8'd200: p = mk(0, 10, -26);
      8'd201: p = mk(0, 8, -26);
      8'd202: p = mk(0, 8, -28);
      // semicolon
      8'd203: p = mk(1, 8, -6);
      8'd204: p = mk(0, 10, -6);
      8'd205: p = mk(0, 10, -4);
      8'd206: p = mk(0, 8, -2);
      8'd207: p = mk(0, 9, -4);
      8'd208: p = mk(0, 8, -4);
      8'd209: p = mk(0, 8, -6);
      8'd210: p = mk(1, 8, -28);
      8'd211: p = mk(0, 10, -28);
      8'd212: p = mk(0, 10, -26);
      8'd213: p = mk(0, 8, -26);
      8'd214: p = mk(0, 8, -28);
      default: p = mk(1, 0, 0);
    endcase
    return p;
  endfunction

  function automatic glyph_t gl(input int base, input int cnt);
    glyph_t g;
    g.known = 1'b1;
    g.base  = ROM_AW'(base);
    g.cnt   = CNT_W'(cnt);
    return g;
  endfunction

  // Character code to first font point and point count.
  function automatic glyph_t glyph_lookup(input logic [CHAR_W-1:0] c);
    glyph_t g;
    unique case (c)
      8'h20: g = gl(0, 0);     // space: advance only
      8'h2C: g = gl(186, 7);
      8'h30: g = gl(0, 7);
      8'h31: g = gl(7, 5);
      8'h32: g = gl(12, 6);
      8'h33: g = gl(18, 6);
      8'h34: g = gl(24, 5);
      8'h35: g = gl(29, 6);
      8'h36: g = gl(35, 6);
      8'h37: g = gl(41, 3);
      8'h38: g = gl(44, 7);
      8'h39: g = gl(51, 6);
      8'h3A: g = gl(193, 10);
      8'h3B: g = gl(203, 12);
      8'h41: g = gl(57, 5);
      8'h42: g = gl(62, 6);
      8'h43: g = gl(68, 4);
      8'h44: g = gl(72, 4);
      8'h45: g = gl(76, 6);
      8'h46: g = gl(82, 5);
      8'h47: g = gl(87, 7);
      8'h48: g = gl(94, 6);
      8'h49: g = gl(100, 6);
      8'h4A: g = gl(106, 4);
      8'h4B: g = gl(110, 5);
      8'h4C: g = gl(115, 3);
      8'h4D: g = gl(118, 5);
      8'h4E: g = gl(123, 4);
      8'h4F: g = gl(127, 5);
      8'h50: g = gl(132, 5);
      8'h51: g = gl(137, 7);
      8'h52: g = gl(144, 7);
      8'h53: g = gl(151, 6);
      8'h54: g = gl(157, 4);
      8'h55: g = gl(161, 4);
      8'h56: g = gl(165, 3);
      8'h57: g = gl(168, 5);
      8'h58: g = gl(173, 4);
      8'h59: g = gl(177, 5);
      8'h5A: g = gl(182, 4);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

@@ sv/vector_text_segment_generator.sv @@
// Top level of the vector text segment generator: stream ports, register port, assertions.
// Depends on vtsg_pkg, vtsg_ctrl and vtsg_dp.
//
// Draws one character per input transaction as line segments of a stroke font (digits,
// capitals, space, comma, colon, semicolon); each segment leaves as one output
// transaction, the final segment of a glyph with out_tlast set. A character is accepted, its
// font points (3 to 12) are walked, the point register is drained and the pen is updated
// in an advance state and a wrap-check state; a point walks the font table one entry per
// cycle through a single point register and stalls while the output register still holds
// an untaken segment. Unknown characters produce nothing; space only moves the pen.
// Registers: scale_x at 0x0, scale_y at 0x4, wrap limit in pixels at 0x8.
module vector_text_segment_generator
  import vtsg_pkg::*;
#(
  parameter int GLYPH_ROM_DEPTH = 256,
  parameter int COORD_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // char_code, origin_x, origin_y, color_rgba
  input  logic        in_tuser,   // start_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // seg_x0, seg_y0, seg_x1, seg_y1, seg_color
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [SCALE_W-1:0] scale_x_r, scale_y_r;
  logic [SW_W-1:0]    wrap_limit_r;
  logic               cfg_wr;
  dp_cmd_t            cmd;
  dp_status_t         st;
  logic [SEG_W-1:0]   seg_x0, seg_y0, seg_x1, seg_y1;
  logic [COLOR_W-1:0] seg_color;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r    <= SCALE_W'(256);
      scale_y_r    <= SCALE_W'(256);
      wrap_limit_r <= SW_W'(640);
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_SCALE_X:  scale_x_r    <= cfg_pwdata[SCALE_W-1:0];
        REG_SCALE_Y:  scale_y_r    <= cfg_pwdata[SCALE_W-1:0];
        REG_SCREEN_W: wrap_limit_r <= cfg_pwdata[SW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_SCALE_X:  cfg_prdata = 32'(scale_x_r);
      REG_SCALE_Y:  cfg_prdata = 32'(scale_y_r);
      REG_SCREEN_W: cfg_prdata = 32'(wrap_limit_r);
      default:      cfg_prdata = '0;
    endcase
  end

  vtsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  vtsg_dp #(
    .GLYPH_ROM_DEPTH (GLYPH_ROM_DEPTH),
    .COORD_BITS      (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .scale_x          (scale_x_r),
    .scale_y          (scale_y_r),
    .wrap_limit       (wrap_limit_r),
    .char_code        (in_tdata[7:0]),
    .start_of_message (in_tuser),
    .origin_x         (in_tdata[23:8]),
    .origin_y         (in_tdata[39:24]),
    .color_rgba       (in_tdata[71:40]),
    .cmd              (cmd),
    .st               (st),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .seg_x0           (seg_x0),
    .seg_y0           (seg_y0),
    .seg_x1           (seg_x1),
    .seg_y1           (seg_y1),
    .seg_color        (seg_color),
    .last_of_glyph    (out_tlast)
  );

  assign out_tdata = {seg_color, seg_y1, seg_x1, seg_y0, seg_x0};

`ifndef SYNTHESIS
  // no font point may still be in flight when a new character can be taken
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !st.pt_vld)
    else $error("point register busy while accepting a character");

  // a segment only moves into the output register when that register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && st.pt_vld && !st.pt_start) |-> st.out_free)
    else $error("segment overwrote an untaken output transaction");

  // fetches stay inside the glyph's range of font points
  a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> st.fetch_more)
    else $error("font point fetched past the end of the glyph");
`endif

endmodule

@@ sv/vtsg_ctrl.sv @@
// Sequencer of the vector text segment generator: accept, point walk, pen update.
// Depends on vtsg_pkg for the command and status structs.
module vtsg_ctrl
  import vtsg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ADV,
    S_WRAP
  } state_t;

  state_t state_r, state_nxt;
  logic   pipe_adv;

  assign in_tready = (state_r == S_IDLE);

  // The point register may move on unless it holds a segment the output cannot take.
  assign pipe_adv = !st.pt_vld || st.pt_start || st.out_free;

  always_comb begin
    cmd          = '0;
    cmd.load     = in_tvalid && (state_r == S_IDLE);
    cmd.step     = (state_r == S_WALK) && pipe_adv;
    cmd.issue    = cmd.step && st.fetch_more;
    cmd.pen_adv  = (state_r == S_ADV);
    cmd.wrap_chk = (state_r == S_WRAP);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          if (!st.known) begin
            state_nxt = S_IDLE;
          end else if (st.empty) begin
            state_nxt = S_ADV;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (!st.fetch_more && !st.pt_vld) begin
          state_nxt = S_ADV;
        end
      end
      S_ADV:  state_nxt = S_WRAP;
      S_WRAP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/vtsg_dp.sv @@
// Datapath of the vector text segment generator: font lookup, point scaling, pen and
// output register. Depends on vtsg_pkg; driven by vtsg_ctrl through dp_cmd_t.
module vtsg_dp
  import vtsg_pkg::*;
#(
  parameter int GLYPH_ROM_DEPTH = 256,
  parameter int COORD_BITS      = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [SCALE_W-1:0]         scale_x,
  input  logic [SCALE_W-1:0]         scale_y,
  input  logic [SW_W-1:0]            wrap_limit,
  input  logic [CHAR_W-1:0]          char_code,
  input  logic                       start_of_message,
  input  logic signed [ORG_W-1:0]    origin_x,
  input  logic signed [ORG_W-1:0]    origin_y,
  input  logic [COLOR_W-1:0]         color_rgba,
  input  dp_cmd_t                    cmd,
  output dp_status_t                 st,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [SEG_W-1:0]           seg_x0,
  output logic [SEG_W-1:0]           seg_y0,
  output logic [SEG_W-1:0]           seg_x1,
  output logic [SEG_W-1:0]           seg_y1,
  output logic [COLOR_W-1:0]         seg_color,
  output logic                       last_of_glyph
);

  localparam int LIM = (GLYPH_ROM_DEPTH < ROM_USED) ? GLYPH_ROM_DEPTH : ROM_USED;
  localparam int CW  = (COORD_BITS < SEG_W) ? COORD_BITS : SEG_W;
  localparam int TW  = ((COORD_BITS > SEG_W) ? COORD_BITS : SEG_W) + 2;
  localparam int AW1 = ROM_AW + 1;

  function automatic logic [COORD_BITS-1:0] scale_pt(input logic signed [PT_HW-1:0] h,
                                                     input logic [SCALE_W-1:0] sc);
    logic [PT_HW-1:0]         mag_h;
    logic [PT_HW+SCALE_W-1:0] prod;
    logic [COORD_BITS-1:0]    mag;
    mag_h = h[PT_HW-1] ? PT_HW'(-h) : PT_HW'(h);
    prod  = (PT_HW+SCALE_W)'(mag_h) * (PT_HW+SCALE_W)'(sc);
    mag   = COORD_BITS'(prod >> HALF_SHIFT);
    return h[PT_HW-1] ? (~mag + COORD_BITS'(1)) : mag;
  endfunction

  // control state
  logic [ROM_AW-1:0]     addr_r, end_r;
  logic                  pt_vld_r, out_vld_r;
  // payload
  logic [COORD_BITS-1:0] pen_x_r, pen_y_r, line_start_x_r;
  logic [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic [COORD_BITS-1:0] pt_x_r, pt_y_r;
  logic                  pt_start_r, pt_last_r;
  logic [COLOR_W-1:0]    color_r;
  logic [SEG_W-1:0]      sx0_r, sy0_r, sx1_r, sy1_r;
  logic [COLOR_W-1:0]    scol_r;
  logic                  slast_r;

  glyph_t                g;
  logic [AW1-1:0]        g_sum, g_end;
  pt_t                   p;
  pt_t                   p_nxt;
  logic                  p_nstart, p_last;
  logic [AW1-1:0]        a1, a2;
  logic                  emit, out_free;
  logic [COORD_BITS-1:0] sum_x0, sum_y0, sum_x1, sum_y1;
  logic [COORD_BITS-1:0] adv_x, adv_y;
  logic signed [COORD_BITS-1:0] pen_x_s;
  logic signed [TW-1:0]  wrap_lhs, wrap_rhs;
  logic [15:0]           adv_x_prod;
  logic [16:0]           adv_y_prod;

  // character lookup, clipped to the usable part of the font
  assign g     = glyph_lookup(char_code);
  assign g_sum = AW1'(g.base) + AW1'(g.cnt);
  assign g_end = (g_sum > AW1'(LIM)) ? AW1'(LIM) : g_sum;

  // current font point and a look at the following one for the final-segment flag
  assign p        = glyph_pt(addr_r);
  assign p_nxt    = glyph_pt(ROM_AW'(addr_r + ROM_AW'(1)));
  assign p_nstart = p_nxt.start;
  assign a1       = AW1'(addr_r) + AW1'(1);
  assign a2       = AW1'(addr_r) + AW1'(2);
  assign p_last   = !p.start &&
                    ((a1 >= AW1'(end_r)) || (p_nstart && (a2 >= AW1'(end_r))));

  assign out_free = !out_vld_r || out_tready;
  assign emit     = cmd.step && pt_vld_r && !pt_start_r;

  assign sum_x0 = pen_x_r + prev_x_r;
  assign sum_y0 = pen_y_r + prev_y_r;
  assign sum_x1 = pen_x_r + pt_x_r;
  assign sum_y1 = pen_y_r + pt_y_r;

  assign adv_x_prod = 16'(scale_x) * 16'(PEN_ADV);
  assign adv_y_prod = 17'(scale_y) * 17'(LINE_ADV);
  assign adv_x      = COORD_BITS'(adv_x_prod >> FRAC_SHIFT);
  assign adv_y      = COORD_BITS'(adv_y_prod >> FRAC_SHIFT);

  assign pen_x_s  = pen_x_r;
  assign wrap_lhs = TW'(pen_x_s) + TW'(WRAP_MARGIN);
  assign wrap_rhs = TW'(signed'({1'b0, wrap_limit}));

  always_comb begin
    st            = '0;
    st.known      = g.known && ((g.cnt == '0) || (AW1'(g.base) < AW1'(LIM)));
    st.empty      = (g.cnt == '0);
    st.fetch_more = (addr_r < end_r);
    st.pt_vld     = pt_vld_r;
    st.pt_start   = pt_start_r;
    st.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r         <= '0;
      end_r          <= '0;
      pt_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      pen_x_r        <= '0;
      pen_y_r        <= '0;
      line_start_x_r <= '0;
      prev_x_r       <= '0;
      prev_y_r       <= '0;
    end else begin
      if (cmd.load) begin
        addr_r   <= g.base;
        end_r    <= ROM_AW'(g_end);
        pt_vld_r <= 1'b0;
        if (start_of_message) begin
          pen_x_r        <= COORD_BITS'(origin_x);
          pen_y_r        <= COORD_BITS'(origin_y);
          line_start_x_r <= COORD_BITS'(origin_x);
        end
      end
      if (cmd.step) begin
        pt_vld_r <= cmd.issue;
        if (pt_vld_r) begin
          prev_x_r <= pt_x_r;
          prev_y_r <= pt_y_r;
        end
      end
      if (cmd.issue) begin
        addr_r <= addr_r + ROM_AW'(1);
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cmd.pen_adv) begin
        pen_x_r <= pen_x_r + adv_x;
      end
      // wrap to the start of the next text line
      if (cmd.wrap_chk && (wrap_lhs >= wrap_rhs)) begin
        pen_x_r <= line_start_x_r;
        pen_y_r <= pen_y_r + adv_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      pt_x_r     <= scale_pt(p.hx, scale_x);
      pt_y_r     <= scale_pt(p.hy, scale_y);
      pt_start_r <= p.start;
      pt_last_r  <= p_last;
    end
    if (cmd.load) begin
      color_r <= color_rgba;
    end
    if (emit) begin
      sx0_r   <= SEG_W'(sum_x0[CW-1:0]);
      sy0_r   <= SEG_W'(sum_y0[CW-1:0]);
      sx1_r   <= SEG_W'(sum_x1[CW-1:0]);
      sy1_r   <= SEG_W'(sum_y1[CW-1:0]);
      scol_r  <= color_r;
      slast_r <= pt_last_r;
    end
  end

  assign out_tvalid    = out_vld_r;
  assign seg_x0        = sx0_r;
  assign seg_y0        = sy0_r;
  assign seg_x1        = sx1_r;
  assign seg_y1        = sy1_r;
  assign seg_color     = scol_r;
  assign last_of_glyph = slast_r;

endmodule

@@ test/tb_vector_text_segment_generator.sv @@
`timescale 1ns / 1ps
// Testbench for vector_text_segment_generator: streams characters in and checks every
// line segment against a behavioral stroke-font predictor across several register settings.
// Depends on vtsg_pkg (register indexes, widths) and the vector_text_segment_generator RTL.
module tb_vector_text_segment_generator;
  import vtsg_pkg::*;

  localparam int IDLE_PCT     = 19;    // percent of cycles a side idles when gaps are on
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES = 8;     // pen update and ignored characters finish in this
  localparam int MAX_SEGS     = 10;
  localparam int PHASES       = 8;
  localparam int PHASE_CHARS  = 42;

  typedef struct packed {
    logic [7:0]        code;
    logic signed [7:0] hx;     // half units
    logic signed [7:0] hy;
    logic              first;  // opens a polyline, draws nothing
  } stroke_pt_t;

  typedef struct packed {
    logic [SEG_W-1:0]   x0;
    logic [SEG_W-1:0]   y0;
    logic [SEG_W-1:0]   x1;
    logic [SEG_W-1:0]   y1;
    logic [COLOR_W-1:0] color;
    logic               last;
  } segment_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata    = '0;   // char_code, origin_x, origin_y, color_rgba
  logic        in_tuser    = 1'b0; // start_of_message
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [95:0] out_tdata;          // seg_x0, seg_y0, seg_x1, seg_y1, seg_color
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state
  stroke_pt_t          font[$];
  segment_t            seg_q[$];
  logic [SCALE_W-1:0]  scale_x    = 12'd256;
  logic [SCALE_W-1:0]  scale_y    = 12'd256;
  logic [SW_W-1:0]     wrap_width = 15'd640;
  logic [SEG_W-1:0]    pen_x      = '0;
  logic [SEG_W-1:0]    pen_y      = '0;
  logic [SEG_W-1:0]    line_x     = '0;
  logic [SEG_W-1:0]    prev_x     = '0;
  logic [SEG_W-1:0]    prev_y     = '0;

  string charset = " ,0123456789:;ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  bit    gaps_on = 1'b1;
  int    errors  = 0;
  int    quiet_cycles = 0;

  vector_text_segment_generator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stroke font, half-unit coordinates
  // ---------------------------------------------------------------------------
  function automatic void mv(input logic [7:0] c, input int hx, input int hy);
    stroke_pt_t p;
    p.code = c; p.hx = 8'(hx); p.hy = 8'(hy); p.first = 1'b1;
    font.push_back(p);
  endfunction

  function automatic void ln(input logic [7:0] c, input int hx, input int hy);
    stroke_pt_t p;
    p.code = c; p.hx = 8'(hx); p.hy = 8'(hy); p.first = 1'b0;
    font.push_back(p);
  endfunction

  function automatic void load_font();
    mv("0", 0, 0); ln("0", 0, -32); ln("0", 16, -32); ln("0", 16, 0);
    ln("0", 0, 0); ln("0", 0, 0); ln("0", 16, -32);
    mv("1", 4, 0); ln("1", 12, 0); mv("1", 8, 0); ln("1", 8, -32); ln("1", 6, -32);
    mv("2", 0, -32); ln("2", 16, -32); ln("2", 16, -16); ln("2", 0, -16);
    ln("2", 0, 0); ln("2", 16, 0);
    mv("3", 0, -32); ln("3", 16, -32); ln("3", 16, 0); ln("3", 0, 0);
    mv("3", 4, -16); ln("3", 16, -16);
    mv("4", 0, -32); ln("4", 0, -16); ln("4", 16, -16); mv("4", 16, -32); ln("4", 16, 0);
    mv("5", 16, -32); ln("5", 0, -32); ln("5", 0, -16); ln("5", 16, -16);
    ln("5", 16, 0); ln("5", 0, 0);
    mv("6", 16, -32); ln("6", 0, -32); ln("6", 0, 0); ln("6", 16, 0);
    ln("6", 16, -16); ln("6", 0, -16);
    mv("7", 0, -32); ln("7", 16, -32); ln("7", 16, 0);
    mv("8", 0, 0); ln("8", 0, -32); ln("8", 16, -32); ln("8", 16, 0);
    ln("8", 0, 0); mv("8", 0, -16); ln("8", 16, -16);
    mv("9", 0, 0); ln("9", 16, 0); ln("9", 16, -32); ln("9", 0, -32);
    ln("9", 0, -16); ln("9", 16, -16);
    mv("A", 0, 0); ln("A", 8, -32); ln("A", 16, 0); mv("A", 4, -16); ln("A", 12, -16);
    mv("B", 0, 0); ln("B", 0, -32); ln("B", 16, -24); ln("B", 0, -16);
    ln("B", 16, -8); ln("B", 0, 0);
    mv("C", 16, 0); ln("C", 0, 0); ln("C", 0, -32); ln("C", 16, -32);
    mv("D", 0, 0); ln("D", 0, -32); ln("D", 16, -16); ln("D", 0, 0);
    mv("E", 16, 0); ln("E", 0, 0); ln("E", 0, -32); ln("E", 16, -32);
    mv("E", 0, -16); ln("E", 12, -16);
    mv("F", 0, 0); ln("F", 0, -32); ln("F", 16, -32); mv("F", 0, -16); ln("F", 12, -16);
    mv("G", 16, -32); ln("G", 0, -32); ln("G", 0, 0); ln("G", 16, 0);
    ln("G", 16, -16); ln("G", 8, -16); ln("G", 8, -12);
    mv("H", 0, 0); ln("H", 0, -32); mv("H", 0, -16); ln("H", 16, -16);
    mv("H", 16, 0); ln("H", 16, -32);
    mv("I", 6, 0); ln("I", 10, 0); mv("I", 6, -32); ln("I", 10, -32);
    mv("I", 8, 0); ln("I", 8, -32);
    mv("J", 16, -32); ln("J", 16, 0); ln("J", 0, 0); ln("J", 0, -8);
    mv("K", 0, 0); ln("K", 0, -32); mv("K", 16, -32); ln("K", 0, -16); ln("K", 16, 0);
    mv("L", 0, -32); ln("L", 0, 0); ln("L", 16, 0);
    mv("M", 0, 0); ln("M", 0, -32); ln("M", 8, -16); ln("M", 16, -32); ln("M", 16, 0);
    mv("N", 0, 0); ln("N", 0, -32); ln("N", 16, 0); ln("N", 16, -32);
    mv("O", 0, 0); ln("O", 0, -32); ln("O", 16, -32); ln("O", 16, 0); ln("O", 0, 0);
    mv("P", 0, 0); ln("P", 0, -32); ln("P", 16, -32); ln("P", 16, -16); ln("P", 0, -16);
    mv("Q", 0, 0); ln("Q", 0, -32); ln("Q", 16, -32); ln("Q", 16, 0);
    ln("Q", 0, 0); mv("Q", 16, 0); ln("Q", 8, -8);
    mv("R", 0, 0); ln("R", 0, -32); ln("R", 16, -32); ln("R", 16, -16);
    ln("R", 0, -16); mv("R", 8, -16); ln("R", 16, 0);
    mv("S", 16, -32); ln("S", 0, -32); ln("S", 0, -16); ln("S", 16, -16);
    ln("S", 16, 0); ln("S", 0, 0);
    mv("T", 0, -32); ln("T", 16, -32); mv("T", 8, 0); ln("T", 8, -32);
    mv("U", 0, -32); ln("U", 0, 0); ln("U", 16, 0); ln("U", 16, -32);
    mv("V", 0, -32); ln("V", 8, 0); ln("V", 16, -32);
    mv("W", 0, -32); ln("W", 4, 0); ln("W", 8, -16); ln("W", 12, 0); ln("W", 16, -32);
    mv("X", 0, -32); ln("X", 16, 0); mv("X", 16, -32); ln("X", 0, 0);
    mv("Y", 0, -32); ln("Y", 8, -16); ln("Y", 16, -32); mv("Y", 8, -16); ln("Y", 8, 0);
    mv("Z", 0, -32); ln("Z", 16, -32); ln("Z", 0, 0); ln("Z", 16, 0);
    // comma tail has one point at 4.5 units
    mv(",", 8, -6); ln(",", 10, -6); ln(",", 10, -4); ln(",", 8, -2);
    ln(",", 9, -4); ln(",", 8, -4); ln(",", 8, -6);
    mv(":", 8, -6); ln(":", 10, -6); ln(":", 10, -4); ln(":", 8, -4); ln(":", 8, -6);
    mv(":", 8, -28); ln(":", 10, -28); ln(":", 10, -26); ln(":", 8, -26); ln(":", 8, -28);
    mv(";", 8, -6); ln(";", 10, -6); ln(";", 10, -4); ln(";", 8, -2);
    ln(";", 9, -4); ln(";", 8, -4); ln(";", 8, -6);
    mv(";", 8, -28); ln(";", 10, -28); ln(";", 10, -26); ln(";", 8, -26); ln(";", 8, -28);
  endfunction

  // ---------------------------------------------------------------------------
  // Segment predictor
  // ---------------------------------------------------------------------------

  // half-unit point times Q4.8 scale, truncated toward zero
  function automatic logic [SEG_W-1:0] scale_pt(input logic signed [7:0] h,
                                                input logic [SCALE_W-1:0] sc);
    int v;
    int mag;
    v   = h;
    mag = ((v < 0 ? -v : v) * int'(sc)) >> 9;
    return (v < 0) ? SEG_W'(-mag) : SEG_W'(mag);
  endfunction

  // Queue the segments of one character and move the pen; returns 1 for a known glyph.
  function automatic bit draw_char(input logic [7:0] ch, input bit som,
                                   input logic [15:0] ox, input logic [15:0] oy,
                                   input logic [31:0] color);
    segment_t         segs[MAX_SEGS];
    int               n;
    bit               known;
    logic [SEG_W-1:0] nx;
    logic [SEG_W-1:0] ny;
    n     = 0;
    known = (ch == " ");  // space is known but has no strokes
    // the origin load happens even for characters outside the font
    if (som) begin
      pen_x  = ox;
      pen_y  = oy;
      line_x = ox;
    end
    for (int i = 0; i < font.size(); i++) begin
      if (font[i].code == ch) begin
        known = 1'b1;
        nx = scale_pt(font[i].hx, scale_x);
        ny = scale_pt(font[i].hy, scale_y);
        if (!font[i].first && n < MAX_SEGS) begin
          segs[n].x0    = pen_x + prev_x;
          segs[n].y0    = pen_y + prev_y;
          segs[n].x1    = pen_x + nx;
          segs[n].y1    = pen_y + ny;
          segs[n].color = color;
          segs[n].last  = 1'b0;
          n++;
        end
        prev_x = nx;
        prev_y = ny;
      end
    end
    if (n > 0) segs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) seg_q.push_back(segs[i]);
    if (known) begin
      pen_x = pen_x + SEG_W'((PEN_ADV * int'(scale_x)) >> FRAC_SHIFT);
      if (int'($signed(pen_x)) + WRAP_MARGIN >= int'(wrap_width)) begin
        pen_x = line_x;
        pen_y = pen_y + SEG_W'((LINE_ADV * int'(scale_y)) >> FRAC_SHIFT);
      end
    end
    return known;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch, input bit som, input logic [15:0] ox,
                           input logic [15:0] oy, input logic [31:0] color,
                           output bit known);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {color, oy, ox, ch};
    in_tuser  <= som;
    do @(posedge clk); while (!in_tready);
    known = draw_char(ch, som, ox, oy, color);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_SCALE_X:  scale_x    = value[SCALE_W-1:0];
      REG_SCALE_Y:  scale_y    = value[SCALE_W-1:0];
      REG_SCREEN_W: wrap_width = value[SW_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input int sx, input int sy, input int width);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_SCREEN_W, width);
  endtask

  // Hold the sender until every queued segment is out and the pen update is done.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (seg_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_scale();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 4095;
      2:       return 256;
      3:       return $urandom_range(128, 512);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic int pick_width();
    case ($urandom_range(0, 4))
      0:       return 1;
      1:       return 32767;
      2:       return $urandom_range(1, 700);
      default: return $urandom_range(1, 32767);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_glyphs();
    bit known;
    send_char("0", 1'b1, 16'd0, 16'd0, 32'hFFFF_FFFF, known);
    send_char("8", 1'b0, 16'd0, 16'd0, 32'h0000_0000, known);
    send_char(" ", 1'b0, 16'hFFFF, 16'hFFFF, 32'h1234_5678, known);
    send_char(8'h00, 1'b0, 16'd0, 16'd0, 32'h0, known);
    send_char(8'hFF, 1'b1, 16'd100, -16'sd50, 32'hA5A5_5A5A, known);
    send_char("A", 1'b0, 16'd0, 16'd0, 32'h8000_0001, known);
    send_char(",", 1'b0, 16'd0, 16'd0, $urandom, known);
    send_char(":", 1'b0, 16'd0, 16'd0, $urandom, known);
    send_char(";", 1'b0, 16'd0, 16'd0, $urandom, known);
    send_char("W", 1'b0, 16'd0, 16'd0, $urandom, known);
    send_char("Q", 1'b0, 16'd0, 16'd0, $urandom, known);
    // origin extremes: coordinates wrap at 16 bits
    send_char("M", 1'b1, 16'h7FFF, 16'h8000, $urandom, known);
    send_char("G", 1'b0, 16'd0, 16'd0, $urandom, known);
  endtask

  task automatic test_line_wrap();
    bit known;
    wait_idle();
    set_config(256, 256, 1);  // wrap limit 1, but the pen starts at the most negative x and does not wrap
    send_char("H", 1'b1, 16'h8000, 16'h7FFF, $urandom, known);
    send_char("T", 1'b0, 16'd0, 16'd0, $urandom, known);
    wait_idle();
    set_config(256, 256, 32767);
    send_char("I", 1'b1, 16'd0, 16'd0, $urandom, known);
    send_char("L", 1'b0, 16'd0, 16'd0, $urandom, known);
    send_char("7", 1'b1, 16'd32750, 16'd0, $urandom, known);
  endtask

  task automatic test_scale_extremes();
    bit known;
    wait_idle();
    set_config(0, 0, 640);  // zero-length segments, pen stays put
    send_char("B", 1'b1, 16'd10, 16'd20, $urandom, known);
    send_char("5", 1'b0, 16'd0, 16'd0, $urandom, known);
    wait_idle();
    set_config(4095, 4095, 640);
    send_char(";", 1'b1, -16'sd1000, -16'sd1000, $urandom, known);
    send_char("0", 1'b0, 16'd0, 16'd0, $urandom, known);
  endtask

  task automatic test_random_text();
    bit         known;
    int         drawn;
    logic [7:0] ch;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      gaps_on = (phase != 3);
      set_config(pick_scale(), pick_scale(), pick_width());
      drawn = 0;
      while (drawn < PHASE_CHARS) begin
        if ($urandom_range(0, 99) < 85)
          ch = charset[$urandom_range(0, charset.len() - 1)];
        else
          ch = 8'($urandom_range(0, 255));
        send_char(ch, $urandom_range(0, 9) == 0, 16'($urandom), 16'($urandom), $urandom,
                  known);
        if (known) drawn++;
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk)
    out_tready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);

  always @(posedge clk) begin : check_segment
    segment_t got;
    segment_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[63:48],
             out_tdata[95:64], out_tlast};
      if (seg_q.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected segment, expected none, got tdata %h last %b",
                   $time, out_tdata, out_tlast);
      end else begin
        want = seg_q.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 30)
            $display("%0t: segment mismatch, expected (%0d,%0d)-(%0d,%0d) %h last %b, got (%0d,%0d)-(%0d,%0d) %h last %b",
                     $time, $signed(want.x0), $signed(want.y0), $signed(want.x1),
                     $signed(want.y1), want.color, want.last, $signed(got.x0),
                     $signed(got.y0), $signed(got.x1), $signed(got.y1), got.color,
                     got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    load_font();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_glyphs();
    test_line_wrap();
    test_scale_extremes();
    test_random_text();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && seg_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
